// ===== hw/rtl/touch_zone_event_tracker_assert.svh =====
// assertion macros for the touch zone event tracker
// used by modules that include this header; no other dependencies
`ifndef TOUCH_ZONE_EVENT_TRACKER_ASSERT_SVH
`define TOUCH_ZONE_EVENT_TRACKER_ASSERT_SVH

// same-cycle implication
`define TZET_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("touch zone event tracker: assertion failed");

// next-cycle implication
`define TZET_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("touch zone event tracker: assertion failed");

`endif

// ===== hw/rtl/tzet_pkg.sv =====
// shared types, codes and zone table for the touch zone event tracker
// no dependencies
package tzet_pkg;

    localparam int NUM_ZONES   = 16;
    localparam int ZONE_DEPTH  = 16;
    localparam int ZONE_CHECK  = (NUM_ZONES < ZONE_DEPTH) ? NUM_ZONES : ZONE_DEPTH;
    localparam int ZONE_IDX_W  = $clog2(ZONE_DEPTH);
    localparam int NUM_SCREENS = 3;
    localparam int SCREEN_W    = 2;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] OP_X       = 2'd0;
    localparam logic [1:0] OP_Y       = 2'd1;
    localparam logic [1:0] OP_CONTACT = 2'd2;
    localparam logic [1:0] OP_KEY     = 2'd3;

    localparam logic [1:0] ACT_PRESS   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_CYCLE   = 2'd2;

    localparam logic [SCREEN_W-1:0] SCREEN_HOME    = SCREEN_W'(0);
    localparam logic [SCREEN_W-1:0] SCREEN_CONTROL = SCREEN_W'(1);
    localparam logic [SCREEN_W-1:0] SCREEN_LAST    = SCREEN_W'(NUM_SCREENS - 1);

    localparam logic [15:0]        TOGGLE_RESET = 16'd112;
    localparam logic signed [17:0] ROT_BASE     = 18'sd279;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] coord_value;
        logic [15:0]        key_usage;
        logic               pressed;
    } t_in_word;

    typedef struct packed {
        logic [1:0]            action;
        logic [ZONE_IDX_W-1:0] button_index;
        logic [SCREEN_W-1:0]   screen_now;
    } t_out_word;

    typedef enum logic {
        CMD_KEY_CYCLE,
        CMD_CONTACT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind             kind;
        logic                  pressed;
        logic                  hit_valid;
        logic [ZONE_IDX_W-1:0] hit_idx;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] x_lo;
        logic signed [15:0] x_hi;
        logic signed [15:0] y_lo;
        logic signed [15:0] y_hi;
    } t_zone;

    localparam t_zone ZONE_ROM [ZONE_DEPTH] = '{
        '{16'sd0,   16'sd59,  16'sd0,   16'sd59},
        '{16'sd220, 16'sd279, 16'sd0,   16'sd59},
        '{16'sd0,   16'sd59,  16'sd180, 16'sd239},
        '{16'sd220, 16'sd279, 16'sd180, 16'sd239},
        '{16'sd55,  16'sd114, 16'sd0,   16'sd59},
        '{16'sd110, 16'sd169, 16'sd0,   16'sd59},
        '{16'sd165, 16'sd224, 16'sd0,   16'sd59},
        '{16'sd55,  16'sd114, 16'sd180, 16'sd239},
        '{16'sd110, 16'sd169, 16'sd180, 16'sd239},
        '{16'sd165, 16'sd224, 16'sd180, 16'sd239},
        '{16'sd0,   16'sd59,  16'sd45,  16'sd104},
        '{16'sd0,   16'sd59,  16'sd90,  16'sd149},
        '{16'sd0,   16'sd59,  16'sd135, 16'sd194},
        '{16'sd220, 16'sd279, 16'sd45,  16'sd104},
        '{16'sd220, 16'sd279, 16'sd90,  16'sd149},
        '{16'sd220, 16'sd279, 16'sd135, 16'sd194}
    };

endpackage

// ===== hw/rtl/tzet_front.sv =====
// front end: accepts input words, latches coordinates, hit-tests zones, queues commands
// depends on tzet_pkg
module tzet_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tzet_pkg::t_in_word i_in_word,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_q_full,
    output logic              o_q_push,
    output tzet_pkg::t_cmd    o_q_cmd
);

    logic signed [15:0] r_touch_x;
    logic signed [15:0] r_touch_y;
    logic [15:0]        r_toggle_key;
    logic signed [17:0] rot_x;
    logic signed [17:0] rot_y;
    logic               hit_valid;
    logic [tzet_pkg::ZONE_IDX_W-1:0] hit_idx;
    logic               accept;
    logic               want_push;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    // rotate latched point onto the control screen frame
    assign rot_x = tzet_pkg::ROT_BASE - {{2{r_touch_y[15]}}, r_touch_y};
    assign rot_y = {{2{r_touch_x[15]}}, r_touch_x};

    // first matching zone wins
    always_comb begin
        hit_valid = 1'b0;
        hit_idx   = '0;
        for (int i = tzet_pkg::ZONE_CHECK - 1; i >= 0; i--) begin
            if (rot_x >= tzet_pkg::ZONE_ROM[i].x_lo && rot_x <= tzet_pkg::ZONE_ROM[i].x_hi &&
                rot_y >= tzet_pkg::ZONE_ROM[i].y_lo && rot_y <= tzet_pkg::ZONE_ROM[i].y_hi) begin
                hit_valid = 1'b1;
                hit_idx   = tzet_pkg::ZONE_IDX_W'(i);
            end
        end
    end

    always_comb begin
        want_push          = 1'b0;
        o_q_cmd.kind       = tzet_pkg::CMD_CONTACT;
        o_q_cmd.pressed    = i_in_word.pressed;
        o_q_cmd.hit_valid  = hit_valid;
        o_q_cmd.hit_idx    = hit_idx;
        unique case (i_in_word.opcode)
            tzet_pkg::OP_X, tzet_pkg::OP_Y: begin
                want_push = 1'b0;
            end
            tzet_pkg::OP_CONTACT: begin
                want_push = 1'b1;
            end
            tzet_pkg::OP_KEY: begin
                o_q_cmd.kind = tzet_pkg::CMD_KEY_CYCLE;
                want_push    = i_in_word.pressed && (i_in_word.key_usage == r_toggle_key);
            end
            default: begin
                want_push = 1'b0;
            end
        endcase
    end

    assign o_q_push = accept && want_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch_x    <= '0;
            r_touch_y    <= '0;
            r_toggle_key <= tzet_pkg::TOGGLE_RESET;
        end else begin
            if (accept && i_in_word.opcode == tzet_pkg::OP_X) begin
                r_touch_x <= i_in_word.coord_value;
            end
            if (accept && i_in_word.opcode == tzet_pkg::OP_Y) begin
                r_touch_y <= i_in_word.coord_value;
            end
            if (i_cfg_we) begin
                r_toggle_key <= i_cfg_wdata;
            end
        end
    end

endmodule

// ===== hw/rtl/tzet_fifo.sv =====
// short command queue between front and back ends
// depends on tzet_pkg and the assertion header
`include "touch_zone_event_tracker_assert.svh"
module tzet_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tzet_pkg::t_cmd i_push_cmd,
    output logic           o_full,
    output logic           o_valid,
    output tzet_pkg::t_cmd o_cmd,
    input  logic           i_pop
);

    tzet_pkg::t_cmd                r_mem [tzet_pkg::FIFO_DEPTH];
    logic [tzet_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [tzet_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [tzet_pkg::FIFO_CNT_W-1:0] r_count;
    logic [tzet_pkg::FIFO_PTR_W-1:0] n_wr_ptr;
    logic [tzet_pkg::FIFO_PTR_W-1:0] n_rd_ptr;
    logic [tzet_pkg::FIFO_CNT_W-1:0] n_count;
    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == tzet_pkg::FIFO_CNT_W'(tzet_pkg::FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == tzet_pkg::FIFO_PTR_W'(tzet_pkg::FIFO_DEPTH - 1)) ?
                       '0 : tzet_pkg::FIFO_PTR_W'(r_wr_ptr + 1'b1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == tzet_pkg::FIFO_PTR_W'(tzet_pkg::FIFO_DEPTH - 1)) ?
                       '0 : tzet_pkg::FIFO_PTR_W'(r_rd_ptr + 1'b1);
        end
        priority if (do_push && !do_pop) begin
            n_count = tzet_pkg::FIFO_CNT_W'(r_count + 1'b1);
        end else if (do_pop && !do_push) begin
            n_count = tzet_pkg::FIFO_CNT_W'(r_count - 1'b1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    `TZET_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= tzet_pkg::FIFO_CNT_W'(tzet_pkg::FIFO_DEPTH))
    `TZET_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, do_push && !do_pop, o_valid)

endmodule

// ===== hw/rtl/tzet_back.sv =====
// back end: screen, contact and held button state, result register
// depends on tzet_pkg and the assertion header
`include "touch_zone_event_tracker_assert.svh"
module tzet_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  tzet_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output tzet_pkg::t_out_word o_out_word
);

    logic [tzet_pkg::SCREEN_W-1:0]   r_screen;
    logic                            r_touching;
    logic                            r_held_valid;
    logic [tzet_pkg::ZONE_IDX_W-1:0] r_held_idx;
    logic                            r_out_valid;
    tzet_pkg::t_out_word             r_out;

    logic [tzet_pkg::SCREEN_W-1:0]   n_screen;
    logic                            n_touching;
    logic                            n_held_valid;
    logic [tzet_pkg::ZONE_IDX_W-1:0] n_held_idx;
    logic                            n_out_valid;
    tzet_pkg::t_out_word             n_out;
    logic [tzet_pkg::SCREEN_W-1:0]   screen_next;
    logic                            on_control;

    assign o_cmd_pop   = i_cmd_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign on_control  = (r_screen == tzet_pkg::SCREEN_CONTROL);
    assign screen_next = (r_screen == tzet_pkg::SCREEN_LAST) ?
                         tzet_pkg::SCREEN_HOME : tzet_pkg::SCREEN_W'(r_screen + 1'b1);

    always_comb begin
        n_screen     = r_screen;
        n_touching   = r_touching;
        n_held_valid = r_held_valid;
        n_held_idx   = r_held_idx;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        if (o_cmd_pop) begin
            unique case (i_cmd.kind)
                tzet_pkg::CMD_KEY_CYCLE: begin
                    n_screen     = screen_next;
                    n_out_valid  = 1'b1;
                    n_out        = '{tzet_pkg::ACT_CYCLE, '0, screen_next};
                end
                tzet_pkg::CMD_CONTACT: begin
                    if (i_cmd.pressed) begin
                        if (!r_touching) begin
                            n_touching = 1'b1;
                            if (on_control && i_cmd.hit_valid) begin
                                n_held_valid = 1'b1;
                                n_held_idx   = i_cmd.hit_idx;
                                n_out_valid  = 1'b1;
                                n_out        = '{tzet_pkg::ACT_PRESS, i_cmd.hit_idx, r_screen};
                            end else begin
                                if (on_control) begin
                                    n_held_valid = 1'b0;
                                end
                                n_screen    = screen_next;
                                n_out_valid = 1'b1;
                                n_out       = '{tzet_pkg::ACT_CYCLE, '0, screen_next};
                            end
                        end
                    end else begin
                        n_touching = 1'b0;
                        if (on_control && r_held_valid) begin
                            n_held_valid = 1'b0;
                            n_out_valid  = 1'b1;
                            n_out        = '{tzet_pkg::ACT_RELEASE, r_held_idx, r_screen};
                        end
                    end
                end
                default: begin
                    n_screen = r_screen;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen     <= tzet_pkg::SCREEN_HOME;
            r_touching   <= 1'b0;
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_screen     <= n_screen;
            r_touching   <= n_touching;
            r_held_valid <= n_held_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held_idx <= n_held_idx;
        r_out      <= n_out;
    end

    `TZET_ASSERT_NOW(a_screen_range, i_clk, i_rst_n, 1'b1, r_screen <= tzet_pkg::SCREEN_LAST)
    `TZET_ASSERT_NOW(a_press_on_control, i_clk, i_rst_n,
        r_out_valid && r_out.action == tzet_pkg::ACT_PRESS,
        r_out.screen_now == tzet_pkg::SCREEN_CONTROL)
    `TZET_ASSERT_NEXT(a_press_holds, i_clk, i_rst_n,
        o_cmd_pop && n_out_valid && n_out.action == tzet_pkg::ACT_PRESS,
        r_held_valid && r_touching)

endmodule

// ===== hw/rtl/touch_zone_event_tracker.sv =====
// top level of the touch zone event tracker: front end, command queue, back end
// depends on tzet_pkg, tzet_front, tzet_fifo and tzet_back
//
//   channel   handshake                     word
//   input     i_in_valid / o_in_stall       i_in_word  (tzet_pkg::t_in_word)
//   output    o_out_valid / i_out_stall     o_out_word (tzet_pkg::t_out_word)
//   config    i_cfg_we                      i_cfg_wdata (toggle key code)
//
// one input word per cycle sustained while o_in_stall is low; a result goes through
// a queue entry and then the output register after its word is taken
// front end hit-tests all zones combinationally; back end updates state on each pop
// two-entry queue between them; o_in_stall rises only when it is full
// a stalled output word holds; the queue absorbs input until full
// synchronous reset clears queue, screen, contact and held button; toggle key 112
module touch_zone_event_tracker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tzet_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tzet_pkg::t_out_word o_out_word,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata
);

    logic           q_full;
    logic           q_push;
    tzet_pkg::t_cmd q_push_cmd;
    logic           q_valid;
    tzet_pkg::t_cmd q_cmd;
    logic           q_pop;

    tzet_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_push_cmd)
    );

    tzet_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_push_cmd),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_cmd      (q_cmd),
        .i_pop      (q_pop)
    );

    tzet_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== tb/sv/touch_zone_event_tracker_tb.sv =====
// testbench for touch_zone_event_tracker: directed and random touch and key words,
// a scoreboard class that predicts each result word and checks the output channel
// depends on tzet_pkg and the touch_zone_event_tracker rtl
module touch_zone_event_tracker_tb;

    localparam int CLK_PERIOD  = 12;
    localparam int HOLD_CYCLES = 40;
    localparam int SETTLE      = 6;

    // x_lo, x_hi, y_lo, y_hi in rotated screen space
    localparam int ZONE_BOX [tzet_pkg::ZONE_DEPTH][4] = '{
        '{0,   59,  0,   59},  '{220, 279, 0,   59},
        '{0,   59,  180, 239}, '{220, 279, 180, 239},
        '{55,  114, 0,   59},  '{110, 169, 0,   59},  '{165, 224, 0,   59},
        '{55,  114, 180, 239}, '{110, 169, 180, 239}, '{165, 224, 180, 239},
        '{0,   59,  45,  104}, '{0,   59,  90,  149}, '{0,   59,  135, 194},
        '{220, 279, 45,  104}, '{220, 279, 90,  149}, '{220, 279, 135, 194}
    };

    class action_scoreboard;
        logic signed [15:0]  last_x;
        logic signed [15:0]  last_y;
        bit                  touching;
        bit                  held_valid;
        logic [3:0]          held_idx;
        logic [1:0]          screen;
        logic [15:0]         toggle_key;
        tzet_pkg::t_out_word pending_actions[$];
        int                  errors;

        function new();
            last_x     = '0;
            last_y     = '0;
            touching   = 1'b0;
            held_valid = 1'b0;
            held_idx   = '0;
            screen     = tzet_pkg::SCREEN_HOME;
            toggle_key = tzet_pkg::TOGGLE_RESET;
            errors     = 0;
        endfunction

        function int first_zone(int px, int py);
            for (int i = 0; i < tzet_pkg::ZONE_DEPTH; i++) begin
                if (px >= ZONE_BOX[i][0] && px <= ZONE_BOX[i][1] &&
                    py >= ZONE_BOX[i][2] && py <= ZONE_BOX[i][3])
                    return i;
            end
            return -1;
        endfunction

        function void advance_screen();
            screen = 2'((int'(screen) + 1) % tzet_pkg::NUM_SCREENS);
        endfunction

        function void note_event(tzet_pkg::t_in_word w);
            tzet_pkg::t_out_word r;
            int                  zone;
            bit                  emit;
            r    = '0;
            emit = 1'b0;
            case (w.opcode)
                tzet_pkg::OP_X: last_x = w.coord_value;
                tzet_pkg::OP_Y: last_y = w.coord_value;
                tzet_pkg::OP_KEY: begin
                    if (w.pressed && w.key_usage == toggle_key) begin
                        advance_screen();
                        r.action = tzet_pkg::ACT_CYCLE;
                        emit     = 1'b1;
                    end
                end
                default: begin
                    if (screen == tzet_pkg::SCREEN_CONTROL) begin
                        if (w.pressed) begin
                            if (!touching) begin
                                touching = 1'b1;
                                zone = first_zone(int'(tzet_pkg::ROT_BASE) - int'(last_y),
                                                  int'(last_x));
                                if (zone >= 0) begin
                                    held_valid     = 1'b1;
                                    held_idx       = 4'(zone);
                                    r.action       = tzet_pkg::ACT_PRESS;
                                    r.button_index = held_idx;
                                end else begin
                                    held_valid = 1'b0;
                                    held_idx   = '0;
                                    advance_screen();
                                    r.action = tzet_pkg::ACT_CYCLE;
                                end
                                emit = 1'b1;
                            end
                        end else begin
                            touching = 1'b0;
                            if (held_valid) begin
                                r.action       = tzet_pkg::ACT_RELEASE;
                                r.button_index = held_idx;
                                held_valid     = 1'b0;
                                held_idx       = '0;
                                emit           = 1'b1;
                            end
                        end
                    end else if (w.pressed) begin
                        if (!touching) begin
                            touching = 1'b1;
                            advance_screen();
                            r.action = tzet_pkg::ACT_CYCLE;
                            emit     = 1'b1;
                        end
                    end else begin
                        touching = 1'b0;
                    end
                end
            endcase
            if (emit) begin
                r.screen_now = screen;
                pending_actions.push_back(r);
            end
        endfunction

        task report(string msg);
            errors++;
            $display("error at %0t: %s", $realtime, msg);
        endtask

        task check_action(tzet_pkg::t_out_word got);
            tzet_pkg::t_out_word want;
            if (pending_actions.size() == 0) begin
                report($sformatf("unexpected word action %0d button %0d screen %0d",
                                 got.action, got.button_index, got.screen_now));
                return;
            end
            want = pending_actions.pop_front();
            if (got.action !== want.action)
                report($sformatf("action %0d, expected %0d", got.action, want.action));
            if (got.button_index !== want.button_index)
                report($sformatf("button_index %0d, expected %0d",
                                 got.button_index, want.button_index));
            if (got.screen_now !== want.screen_now)
                report($sformatf("screen_now %0d, expected %0d",
                                 got.screen_now, want.screen_now));
        endtask
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    tzet_pkg::t_in_word  in_word   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    tzet_pkg::t_out_word out_word;
    logic                cfg_we    = 1'b0;
    logic [15:0]         cfg_wdata = '0;

    action_scoreboard board = new();
    bit gaps_on      = 1'b1;
    bit hold_request = 1'b0;
    int sent         = 0;

    touch_zone_event_tracker uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial begin
        #(CLK_PERIOD * 400000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            board.check_action(out_word);
    end

    // receiver back-pressure
    initial begin
        forever begin
            @(negedge clk);
            if (hold_request) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    task automatic send_word(input logic [1:0] op, input logic [15:0] coord,
                             input logic [15:0] key, input logic press);
        tzet_pkg::t_in_word w;
        w.opcode      = op;
        w.coord_value = coord;
        w.key_usage   = key;
        w.pressed     = press;
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_event(w);
        sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending_actions.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_toggle(input logic [15:0] key);
        cfg_we    <= 1'b1;
        cfg_wdata <= key;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.toggle_key = key;
    endtask

    task automatic key_event();
        case ($urandom_range(0, 5))
            0: send_word(tzet_pkg::OP_KEY, 16'($urandom), 16'($urandom), 1'($urandom));
            1: send_word(tzet_pkg::OP_KEY, 16'($urandom), board.toggle_key, 1'b0);
            default: send_word(tzet_pkg::OP_KEY, 16'($urandom), board.toggle_key, 1'b1);
        endcase
    endtask

    // coordinates mostly around the zone grid, then a press and usually a release
    task automatic touch_gesture();
        if ($urandom_range(0, 3) != 0)
            send_word(tzet_pkg::OP_X, 16'(int'($urandom_range(0, 270)) - 10), 16'($urandom),
                      1'($urandom));
        if ($urandom_range(0, 3) != 0)
            send_word(tzet_pkg::OP_Y, 16'(int'($urandom_range(0, 300)) - 10), 16'($urandom),
                      1'($urandom));
        send_word(tzet_pkg::OP_CONTACT, 16'($urandom), 16'($urandom), 1'b1);
        if ($urandom_range(0, 4) == 0)
            send_word(tzet_pkg::OP_CONTACT, 16'($urandom), 16'($urandom), 1'b1);
        if ($urandom_range(0, 5) == 0)
            key_event();
        if ($urandom_range(0, 7) != 0)
            send_word(tzet_pkg::OP_CONTACT, 16'($urandom), 16'($urandom), 1'b0);
    endtask

    task automatic random_traffic(input int count);
        int                 stop;
        tzet_pkg::t_in_word raw;
        stop = sent + count;
        while (sent < stop) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: touch_gesture();
                5, 6: key_event();
                7: send_word(tzet_pkg::OP_CONTACT, 16'($urandom), 16'($urandom),
                             1'($urandom));
                default: begin
                    raw = tzet_pkg::t_in_word'(35'({$urandom, $urandom}));
                    send_word(raw.opcode, raw.coord_value, raw.key_usage, raw.pressed);
                end
            endcase
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_word(tzet_pkg::OP_X, 16'h7FFF, 16'h0000, 1'b0);
        send_word(tzet_pkg::OP_Y, 16'h8000, 16'hFFFF, 1'b1);
        send_word(tzet_pkg::OP_KEY, 16'h0000, tzet_pkg::TOGGLE_RESET, 1'b0);
        send_word(tzet_pkg::OP_KEY, 16'hFFFF, 16'd111, 1'b1);
        send_word(tzet_pkg::OP_KEY, 16'h0000, tzet_pkg::TOGGLE_RESET, 1'b1);
        send_word(tzet_pkg::OP_CONTACT, 16'h0000, 16'h0000, 1'b1);
        send_word(tzet_pkg::OP_CONTACT, 16'hFFFF, 16'hFFFF, 1'b1);
        send_word(tzet_pkg::OP_CONTACT, 16'h0000, 16'h0000, 1'b0);
        send_word(tzet_pkg::OP_KEY, 16'h0000, tzet_pkg::TOGGLE_RESET, 1'b1);
        send_word(tzet_pkg::OP_CONTACT, 16'h0000, 16'h0000, 1'b1);
        send_word(tzet_pkg::OP_CONTACT, 16'h0000, 16'h0000, 1'b0);
        send_word(tzet_pkg::OP_X, 16'd30, 16'h0000, 1'b0);
        send_word(tzet_pkg::OP_Y, 16'd250, 16'h0000, 1'b0);
        send_word(tzet_pkg::OP_CONTACT, 16'h0000, 16'h0000, 1'b1);
        send_word(tzet_pkg::OP_CONTACT, 16'h0000, 16'h0000, 1'b1);
        send_word(tzet_pkg::OP_KEY, 16'h0000, tzet_pkg::TOGGLE_RESET, 1'b1);
        send_word(tzet_pkg::OP_CONTACT, 16'h0000, 16'h0000, 1'b0);
        send_word(tzet_pkg::OP_KEY, 16'h0000, tzet_pkg::TOGGLE_RESET, 1'b1);
        send_word(tzet_pkg::OP_KEY, 16'h0000, tzet_pkg::TOGGLE_RESET, 1'b1);
        send_word(tzet_pkg::OP_CONTACT, 16'h0000, 16'h0000, 1'b0);
        send_word(tzet_pkg::OP_X, 16'd170, 16'h0000, 1'b0);
        send_word(tzet_pkg::OP_Y, 16'd0, 16'h0000, 1'b0);
        send_word(tzet_pkg::OP_CONTACT, 16'h0000, 16'h0000, 1'b1);
        send_word(tzet_pkg::OP_CONTACT, 16'h0000, 16'h0000, 1'b0);
        send_word(tzet_pkg::OP_X, 16'd57, 16'h0000, 1'b0);
        send_word(tzet_pkg::OP_Y, 16'd222, 16'h0000, 1'b0);
        send_word(tzet_pkg::OP_CONTACT, 16'h0000, 16'h0000, 1'b1);
        send_word(tzet_pkg::OP_CONTACT, 16'h0000, 16'h0000, 1'b0);
        send_word(tzet_pkg::OP_X, 16'd100, 16'h0000, 1'b0);
        send_word(tzet_pkg::OP_Y, 16'hFFFF, 16'h0000, 1'b0);
        send_word(tzet_pkg::OP_CONTACT, 16'h0000, 16'h0000, 1'b1);
        drain();

        // long output hold while key words keep coming
        hold_request = 1'b1;
        repeat (24) send_word(tzet_pkg::OP_KEY, 16'($urandom), board.toggle_key, 1'b1);
        random_traffic(230);
        drain();

        write_toggle(16'h0000);
        random_traffic(250);
        drain();
        write_toggle(16'hFFFF);
        random_traffic(250);
        drain();
        write_toggle(16'($urandom));
        random_traffic(250);
        drain();
        write_toggle(tzet_pkg::TOGGLE_RESET);
        gaps_on = 1'b0;
        random_traffic(220);
        drain();

        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
